[rtl/frame_difference_metrics_defines.svh]
// ----------------------------------------------------------------------------
// Frame difference metrics: assertion macros
// Concurrent check wrappers for the RTL top level; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef FRAME_DIFFERENCE_METRICS_DEFINES_SVH
`define FRAME_DIFFERENCE_METRICS_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every rising clock edge outside reset.
`define FDM_ASSERT(label, ck, rn, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("frame difference metrics: property violated");

// Check that a condition never occurs outside reset.
`define FDM_ASSERT_NEVER(label, ck, rn, cond) \
    label: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("frame difference metrics: forbidden condition seen");

`else

`define FDM_ASSERT(label, ck, rn, prop)
`define FDM_ASSERT_NEVER(label, ck, rn, cond)

`endif

`endif

[rtl/fdm_pkg.sv]
// ----------------------------------------------------------------------------
// fdm_pkg
// Shared widths, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package fdm_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;

    localparam int PIX_W      = 8;
    localparam int COUNT_W    = 13;
    localparam int WEIGHT_W   = 16;
    localparam int SCORE_W    = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Shared serial divider: wide enough for the score numerator
    // (weighted delta times 10000 plus rounding term).
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 26;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_WEIGHT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_WEIGHT        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION_WEIGHT = 2'd3;

    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 13'd4096;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd1;

    typedef struct packed {
        logic [PIX_W-1:0]   mean_luma;
        logic [PIX_W-1:0]   delta_luma;
        logic [PIX_W-1:0]   delta_hue;
        logic [PIX_W-1:0]   delta_saturation;
        logic [SCORE_W-1:0] content_score;
        logic               had_previous;
    } result_t;

endpackage

`default_nettype wire

[rtl/fdm_plane_mem.sv]
// ----------------------------------------------------------------------------
// fdm_plane_mem
// Previous-frame sample store: one port, read old entry and write new one.
// ----------------------------------------------------------------------------
`default_nettype none

module fdm_plane_mem #(
    parameter int DEPTH  = fdm_pkg::MAX_SAMPLES_DEF,
    parameter int ADDR_W = $clog2(fdm_pkg::MAX_SAMPLES_DEF)
) (
    input  logic                       clk,
    input  logic                       write,
    input  logic [ADDR_W-1:0]          addr,
    input  logic [3*fdm_pkg::PIX_W-1:0] wdata,
    output logic [3*fdm_pkg::PIX_W-1:0] rdata
);

    logic [3*fdm_pkg::PIX_W-1:0] mem [DEPTH];
    logic [3*fdm_pkg::PIX_W-1:0] rdata_reg;

    // Read-before-write: the registered read returns the stored entry.
    always_ff @(posedge clk)
    begin
        if (write)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/fdm_accum.sv]
// ----------------------------------------------------------------------------
// fdm_accum
// Second stage: difference against the stored sample and running sums.
// ----------------------------------------------------------------------------
`default_nettype none

module fdm_accum #(
    parameter int SUM_W = 21
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        take,
    input  logic [fdm_pkg::PIX_W-1:0]   luma,
    input  logic [fdm_pkg::PIX_W-1:0]   hue,
    input  logic [fdm_pkg::PIX_W-1:0]   saturation,
    input  logic                        compare,
    input  logic                        last,
    input  logic [3*fdm_pkg::PIX_W-1:0] prior,
    output logic                        frame_done,
    output logic                        frame_compare,
    output logic [SUM_W-1:0]            luma_total,
    output logic [SUM_W-1:0]            luma_diff_total,
    output logic [SUM_W-1:0]            hue_diff_total,
    output logic [SUM_W-1:0]            sat_diff_total
);

    localparam int P = fdm_pkg::PIX_W;
    localparam logic [P-1:0] HALF_TURN = P'(2 ** (P - 1));

    function automatic logic [P-1:0] abs_diff(input logic [P-1:0] a, input logic [P-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Circular distance over 256: min(d, 256 - d).
    function automatic logic [P-1:0] circ_dist(input logic [P-1:0] a, input logic [P-1:0] b);
        logic [P-1:0] d;
        d = abs_diff(a, b);
        return (d > HALF_TURN) ? P'((P+1)'(2 ** P) - {1'b0, d}) : d;
    endfunction

    logic             s2_valid_reg;
    logic             s2_cmp_reg;
    logic             s2_last_reg;
    logic [P-1:0]     s2_luma_reg;
    logic [P-1:0]     s2_hue_reg;
    logic [P-1:0]     s2_sat_reg;

    logic [SUM_W-1:0] luma_sum_reg;
    logic [SUM_W-1:0] luma_diff_reg;
    logic [SUM_W-1:0] hue_diff_reg;
    logic [SUM_W-1:0] sat_diff_reg;

    logic [P-1:0]     d_luma;
    logic [P-1:0]     d_hue;
    logic [P-1:0]     d_sat;

    always_comb
    begin
        d_luma = '0;
        d_hue  = '0;
        d_sat  = '0;
        if (s2_cmp_reg)
        begin
            d_luma = abs_diff(s2_luma_reg, prior[3*P-1:2*P]);
            d_hue  = circ_dist(s2_hue_reg, prior[2*P-1:P]);
            d_sat  = abs_diff(s2_sat_reg, prior[P-1:0]);
        end
    end

    assign luma_total      = luma_sum_reg  + SUM_W'(s2_luma_reg);
    assign luma_diff_total = luma_diff_reg + SUM_W'(d_luma);
    assign hue_diff_total  = hue_diff_reg  + SUM_W'(d_hue);
    assign sat_diff_total  = sat_diff_reg  + SUM_W'(d_sat);

    assign frame_done    = s2_valid_reg & s2_last_reg;
    assign frame_compare = s2_cmp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s2_cmp_reg    <= 1'b0;
            s2_last_reg   <= 1'b0;
            luma_sum_reg  <= '0;
            luma_diff_reg <= '0;
            hue_diff_reg  <= '0;
            sat_diff_reg  <= '0;
        end
        else
        begin
            s2_valid_reg <= take;
            if (take)
            begin
                s2_cmp_reg  <= compare;
                s2_last_reg <= last;
            end
            // Drop the sums at frame end (the finisher has taken them) or on clear.
            if (clear || frame_done)
            begin
                luma_sum_reg  <= '0;
                luma_diff_reg <= '0;
                hue_diff_reg  <= '0;
                sat_diff_reg  <= '0;
            end
            else if (s2_valid_reg)
            begin
                luma_sum_reg  <= luma_total;
                luma_diff_reg <= luma_diff_total;
                hue_diff_reg  <= hue_diff_total;
                sat_diff_reg  <= sat_diff_total;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_luma_reg <= luma;
            s2_hue_reg  <= hue;
            s2_sat_reg  <= saturation;
        end
    end

endmodule

`default_nettype wire

[rtl/fdm_divider.sv]
// ----------------------------------------------------------------------------
// fdm_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdm_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fdm_pkg::DIV_NUM_W-1:0] numer,
    input  logic [fdm_pkg::DIV_DEN_W-1:0] denom,
    output logic                          done,
    output logic [fdm_pkg::DIV_NUM_W-1:0] quotient
);

    localparam int NW    = fdm_pkg::DIV_NUM_W;
    localparam int DW    = fdm_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NW);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NW - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;

    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             fits;
    logic [DW-1:0]    rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= LAST_STEP;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/fdm_finish.sv]
// ----------------------------------------------------------------------------
// fdm_finish
// End-of-frame sequencer: rounded means, weighted score, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdm_finish #(
    parameter int N_W   = 13,
    parameter int SUM_W = 21
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           frame_done,
    input  logic                           frame_compare,
    input  logic [SUM_W-1:0]               luma_total,
    input  logic [SUM_W-1:0]               luma_diff_total,
    input  logic [SUM_W-1:0]               hue_diff_total,
    input  logic [SUM_W-1:0]               sat_diff_total,
    input  logic [N_W-1:0]                 count,
    input  logic [fdm_pkg::WEIGHT_W-1:0]   luma_weight,
    input  logic [fdm_pkg::WEIGHT_W-1:0]   hue_weight,
    input  logic [fdm_pkg::WEIGHT_W-1:0]   sat_weight,
    input  logic                           result_stall,
    output logic                           busy,
    output logic                           result_valid,
    output fdm_pkg::result_t               result
);

    localparam int P      = fdm_pkg::PIX_W;
    localparam int W      = fdm_pkg::WEIGHT_W;
    localparam int NW     = fdm_pkg::DIV_NUM_W;
    localparam int DW     = fdm_pkg::DIV_DEN_W;
    localparam int SW     = fdm_pkg::SCORE_W;
    localparam int WSUM_W = W + 2;
    localparam int WDOT_W = P + W + 2;
    localparam logic [SW-1:0] ScoreScale = SW'(10000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_WEIGHT,
        ST_SCALE,
        ST_SCORE_GO,
        ST_SCORE_WAIT,
        ST_HAND
    } state_t;

    state_t            state_reg;
    logic [1:0]        sel_reg;
    logic              cmp_reg;
    logic              result_valid_reg;
    fdm_pkg::result_t  result_reg;

    logic [SUM_W-1:0]  sum_reg [4];
    logic [P-1:0]      mean_reg [4];
    logic [WDOT_W-1:0] wd_reg;
    logic [WSUM_W-1:0] ws_reg;
    logic [NW-1:0]     prod_reg;
    logic [SW-1:0]     score_reg;

    logic              div_start;
    logic [NW-1:0]     div_num;
    logic [DW-1:0]     div_den;
    logic              div_done;
    logic [NW-1:0]     div_quo;

    logic [W-1:0]      weight_sel;
    logic [WDOT_W-1:0] wd_term;
    logic [NW-1:0]     scaled;
    logic [WSUM_W-1:0] ws_sum;
    fdm_pkg::result_t  assembled;

    fdm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_num),
        .denom    (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        case (sel_reg)
            2'd0:    weight_sel = luma_weight;
            2'd1:    weight_sel = hue_weight;
            default: weight_sel = sat_weight;
        endcase
        wd_term = WDOT_W'(mean_reg[sel_reg + 2'd1] * weight_sel);
        ws_sum  = WSUM_W'(luma_weight) + WSUM_W'(hue_weight) + WSUM_W'(sat_weight);
        scaled  = wd_reg * ScoreScale;

        // Rounded mean: (sum + n/2) / n; score: (wd*10000 + 127*ws) / (255*ws).
        if (state_reg == ST_MEAN_GO)
        begin
            div_num = NW'(sum_reg[sel_reg]) + NW'(count[N_W-1:1]);
            div_den = DW'(count);
        end
        else
        begin
            div_num = prod_reg + NW'({ws_reg, 7'b0}) - NW'(ws_reg);
            div_den = DW'({ws_reg, 8'b0}) - DW'(ws_reg);
        end
        div_start = (state_reg == ST_MEAN_GO) ||
                    ((state_reg == ST_SCORE_GO) && (ws_reg != '0));

        assembled.mean_luma        = mean_reg[0];
        assembled.delta_luma       = cmp_reg ? mean_reg[1] : '0;
        assembled.delta_hue        = cmp_reg ? mean_reg[2] : '0;
        assembled.delta_saturation = cmp_reg ? mean_reg[3] : '0;
        assembled.content_score    = cmp_reg ? score_reg : '0;
        assembled.had_previous     = cmp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sel_reg          <= '0;
            cmp_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (frame_done)
                    begin
                        cmp_reg   <= frame_compare;
                        sel_reg   <= '0;
                        state_reg <= ST_MEAN_GO;
                    end
                end
                ST_MEAN_GO:
                begin
                    state_reg <= ST_MEAN_WAIT;
                end
                ST_MEAN_WAIT:
                begin
                    if (div_done)
                    begin
                        if ((sel_reg == 2'd3) || !cmp_reg)
                        begin
                            sel_reg   <= '0;
                            state_reg <= cmp_reg ? ST_WEIGHT : ST_HAND;
                        end
                        else
                        begin
                            sel_reg   <= sel_reg + 2'd1;
                            state_reg <= ST_MEAN_GO;
                        end
                    end
                end
                ST_WEIGHT:
                begin
                    if (sel_reg == 2'd2)
                    begin
                        state_reg <= ST_SCALE;
                    end
                    sel_reg <= sel_reg + 2'd1;
                end
                ST_SCALE:
                begin
                    state_reg <= ST_SCORE_GO;
                end
                ST_SCORE_GO:
                begin
                    state_reg <= (ws_reg != '0) ? ST_SCORE_WAIT : ST_HAND;
                end
                ST_SCORE_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_HAND;
                    end
                end
                ST_HAND:
                begin
                    // Load the result once the output slot is free.
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_reg       <= assembled;
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_done)
                begin
                    sum_reg[0] <= luma_total;
                    sum_reg[1] <= luma_diff_total;
                    sum_reg[2] <= hue_diff_total;
                    sum_reg[3] <= sat_diff_total;
                end
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    mean_reg[sel_reg] <= div_quo[P-1:0];
                end
            end
            ST_WEIGHT:
            begin
                wd_reg <= ((sel_reg == 2'd0) ? '0 : wd_reg) + wd_term;
            end
            ST_SCALE:
            begin
                ws_reg   <= ws_sum;
                prod_reg <= scaled;
            end
            ST_SCORE_GO:
            begin
                if (ws_reg == '0)
                begin
                    score_reg <= '0;
                end
            end
            ST_SCORE_WAIT:
            begin
                if (div_done)
                begin
                    score_reg <= div_quo[SW-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

[rtl/frame_difference_metrics.sv]
// ----------------------------------------------------------------------------
// frame_difference_metrics
// Mean luma and mean frame-to-frame luma, hue and saturation deltas per frame.
// ----------------------------------------------------------------------------
// Each request carries one downscaled sample (luma, hue, saturation). Samples
// are taken one per clock within a frame: the sample store is read and
// rewritten at the same address in the accept cycle, and the differences and
// running sums are formed in the cycle after. use_previous counts only on the
// first sample of a frame, and the frame is compared only if a full frame of
// the current size is already stored. After the last sample of a frame the
// sample side stalls while a shared one-bit-per-cycle divider (40 steps per
// division) forms the rounded means and the content score (all four means and
// the score for a compared frame, the mean luma only otherwise). A finished
// result sits in an output register, so the next frame may start while it
// waits to be taken. Writing sample_count abandons the frame in progress and a
// change of the effective size invalidates the stored frame. Weights are read
// at frame end. The store needs no clearing: unwritten entries go unused.
// ----------------------------------------------------------------------------
`default_nettype none
`include "frame_difference_metrics_defines.svh"

module frame_difference_metrics #(
    parameter int MAX_SAMPLES = fdm_pkg::MAX_SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration write port
    input  logic                            cfg_write,
    input  logic [fdm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fdm_pkg::CFG_DATA_W-1:0]  cfg_data,

    // sample requests
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [fdm_pkg::PIX_W-1:0]       luma,
    input  logic [fdm_pkg::PIX_W-1:0]       hue,
    input  logic [fdm_pkg::PIX_W-1:0]       saturation,
    input  logic                            use_previous,

    // frame results
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [fdm_pkg::PIX_W-1:0]       mean_luma,
    output logic [fdm_pkg::PIX_W-1:0]       delta_luma,
    output logic [fdm_pkg::PIX_W-1:0]       delta_hue,
    output logic [fdm_pkg::PIX_W-1:0]       delta_saturation,
    output logic [fdm_pkg::SCORE_W-1:0]     content_score,
    output logic                            had_previous
);

    localparam int CW    = fdm_pkg::COUNT_W;
    localparam int WW    = fdm_pkg::WEIGHT_W;
    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    // compare width covers both the register and the parameter
    localparam int CMP_W = (CNT_W > CW) ? CNT_W : CW;
    // the effective count never exceeds either of them
    localparam int N_W   = (CNT_W < CW) ? CNT_W : CW;
    localparam int SUM_W = fdm_pkg::PIX_W + N_W;

    // Zero acts as one; counts above the store depth clamp to it.
    function automatic logic [N_W-1:0] eff_count(input logic [CW-1:0] v);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(v);
        if (v == '0)
        begin
            return N_W'(1);
        end
        else if (wide > CMP_W'(MAX_SAMPLES))
        begin
            return N_W'(MAX_SAMPLES);
        end
        else
        begin
            return N_W'(wide);
        end
    endfunction

    // configuration registers
    logic [CW-1:0]    count_reg;
    logic [WW-1:0]    luma_weight_reg;
    logic [WW-1:0]    hue_weight_reg;
    logic [WW-1:0]    sat_weight_reg;

    // frame control
    logic [IDX_W-1:0] sample_index_reg;
    logic             frame_compares_reg;
    logic             prior_valid_reg;

    logic [N_W-1:0]   n_eff;
    logic             accept;
    logic             first;
    logic             cmp_now;
    logic [CMP_W-1:0] idx_inc;
    logic             last;
    logic             count_write;

    logic [3*fdm_pkg::PIX_W-1:0] prior;
    logic             frame_done;
    logic             frame_compare;
    logic [SUM_W-1:0] luma_total;
    logic [SUM_W-1:0] luma_diff_total;
    logic [SUM_W-1:0] hue_diff_total;
    logic [SUM_W-1:0] sat_diff_total;
    logic             fin_busy;
    fdm_pkg::result_t result;

    assign n_eff   = eff_count(count_reg);
    // Hold samples while a frame end is in the second stage or being finished.
    assign sample_stall = fin_busy | frame_done;
    assign accept  = sample_valid & ~sample_stall;
    assign first   = (sample_index_reg == '0);
    assign cmp_now = first ? (use_previous & prior_valid_reg) : frame_compares_reg;
    assign idx_inc = CMP_W'(sample_index_reg) + CMP_W'(1);
    assign last    = (idx_inc == CMP_W'(n_eff));
    assign count_write = cfg_write && (cfg_index == fdm_pkg::REG_SAMPLE_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg          <= fdm_pkg::COUNT_RESET;
            luma_weight_reg    <= fdm_pkg::WEIGHT_RESET;
            hue_weight_reg     <= fdm_pkg::WEIGHT_RESET;
            sat_weight_reg     <= fdm_pkg::WEIGHT_RESET;
            sample_index_reg   <= '0;
            frame_compares_reg <= 1'b0;
            prior_valid_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fdm_pkg::REG_SAMPLE_COUNT:
                begin
                    // Drop the frame in progress; a new size voids the store.
                    if (eff_count(cfg_data[CW-1:0]) != n_eff)
                    begin
                        prior_valid_reg <= 1'b0;
                    end
                    count_reg          <= cfg_data[CW-1:0];
                    sample_index_reg   <= '0;
                    frame_compares_reg <= 1'b0;
                end
                fdm_pkg::REG_LUMA_WEIGHT:       luma_weight_reg <= cfg_data[WW-1:0];
                fdm_pkg::REG_HUE_WEIGHT:        hue_weight_reg  <= cfg_data[WW-1:0];
                fdm_pkg::REG_SATURATION_WEIGHT: sat_weight_reg  <= cfg_data[WW-1:0];
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            frame_compares_reg <= cmp_now;
            if (last)
            begin
                // A full frame of the current size is now stored.
                sample_index_reg <= '0;
                prior_valid_reg  <= 1'b1;
            end
            else
            begin
                sample_index_reg <= idx_inc[IDX_W-1:0];
            end
        end
    end

    fdm_plane_mem #(
        .DEPTH  (MAX_SAMPLES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .write (accept),
        .addr  (sample_index_reg),
        .wdata ({luma, hue, saturation}),
        .rdata (prior)
    );

    fdm_accum #(
        .SUM_W (SUM_W)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .clear           (count_write),
        .take            (accept),
        .luma            (luma),
        .hue             (hue),
        .saturation      (saturation),
        .compare         (cmp_now),
        .last            (last),
        .prior           (prior),
        .frame_done      (frame_done),
        .frame_compare   (frame_compare),
        .luma_total      (luma_total),
        .luma_diff_total (luma_diff_total),
        .hue_diff_total  (hue_diff_total),
        .sat_diff_total  (sat_diff_total)
    );

    fdm_finish #(
        .N_W   (N_W),
        .SUM_W (SUM_W)
    ) u_finish (
        .clk             (clk),
        .rst_n           (rst_n),
        .frame_done      (frame_done),
        .frame_compare   (frame_compare),
        .luma_total      (luma_total),
        .luma_diff_total (luma_diff_total),
        .hue_diff_total  (hue_diff_total),
        .sat_diff_total  (sat_diff_total),
        .count           (n_eff),
        .luma_weight     (luma_weight_reg),
        .hue_weight      (hue_weight_reg),
        .sat_weight      (sat_weight_reg),
        .result_stall    (result_stall),
        .busy            (fin_busy),
        .result_valid    (result_valid),
        .result          (result)
    );

    assign mean_luma        = result.mean_luma;
    assign delta_luma       = result.delta_luma;
    assign delta_hue        = result.delta_hue;
    assign delta_saturation = result.delta_saturation;
    assign content_score    = result.content_score;
    assign had_previous     = result.had_previous;

    // A frame end must never reach a finisher that is still busy.
    `FDM_ASSERT_NEVER(a_done_while_busy, clk, rst_n, frame_done && fin_busy)
    // The store position stays inside the current frame.
    `FDM_ASSERT(a_index_in_frame, clk, rst_n, CMP_W'(sample_index_reg) < CMP_W'(n_eff))
    // A compared frame always has a stored frame behind it.
    `FDM_ASSERT(a_compare_needs_prior, clk, rst_n, frame_compares_reg |-> prior_valid_reg)

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: frame difference metrics testbench
// Streams luma/hue/saturation sample requests through the block under random
// flow control on both channels. A software copy of the frame store and the
// running sums predicts each frame's means, deltas and content score, and
// every result taken from the block is compared field by field in order.
// ----------------------------------------------------------------------------

module tb_top;

    import fdm_pkg::*;

    localparam int STORE_DEPTH   = MAX_SAMPLES_DEF;
    localparam int DRAIN_CYCLES  = 300;       // worst frame-end divide plus margin
    localparam int RANDOM_ITEMS  = 1600;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] saturation;
        logic             use_previous;
    } sample_req_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input is known from time zero
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    logic [PIX_W-1:0]      luma = '0;
    logic [PIX_W-1:0]      hue = '0;
    logic [PIX_W-1:0]      saturation = '0;
    logic                  use_previous = 1'b0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [PIX_W-1:0]      mean_luma;
    logic [PIX_W-1:0]      delta_luma;
    logic [PIX_W-1:0]      delta_hue;
    logic [PIX_W-1:0]      delta_saturation;
    logic [SCORE_W-1:0]    content_score;
    logic                  had_previous;

    frame_difference_metrics DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .luma             (luma),
        .hue              (hue),
        .saturation       (saturation),
        .use_previous     (use_previous),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .mean_luma        (mean_luma),
        .delta_luma       (delta_luma),
        .delta_hue        (delta_hue),
        .delta_saturation (delta_saturation),
        .content_score    (content_score),
        .had_previous     (had_previous)
    );

    // ------------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // The slowest legal run stays well below this even with every gap at its
    // longest; only a hung handshake gets here.
    initial
    begin
        #(100_000_000);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------------
    sample_req_t pending_requests[$];   // requests not yet offered to the block
    result_t     expected_metrics[$];   // frame results still owed by the block
    int unsigned pushed_total = 0;
    int unsigned accepted_total = 0;
    int unsigned error_count = 0;
    int unsigned frames_checked = 0;
    int unsigned compared_frames = 0;
    int unsigned register_writes = 0;
    bit          calm = 1'b0;           // phase with no idling on either side

    // ------------------------------------------------------------------------
    // Frame metrics predictor: own copy of registers, store and running sums
    // ------------------------------------------------------------------------
    logic [3*PIX_W-1:0]  stored_frame [STORE_DEPTH];
    bit                  stored_ok = 1'b0;
    bit                  cur_compares = 1'b0;
    int unsigned         cur_pos = 0;
    int unsigned         sum_luma = 0;
    int unsigned         sum_dluma = 0;
    int unsigned         sum_dhue = 0;
    int unsigned         sum_dsat = 0;
    logic [COUNT_W-1:0]  reg_count = COUNT_RESET;
    logic [WEIGHT_W-1:0] reg_wluma = WEIGHT_RESET;
    logic [WEIGHT_W-1:0] reg_whue = WEIGHT_RESET;
    logic [WEIGHT_W-1:0] reg_wsat = WEIGHT_RESET;

    function automatic int unsigned frame_size(input logic [COUNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > STORE_DEPTH)
            return STORE_DEPTH;
        return v;
    endfunction

    function automatic int unsigned byte_dist(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // hue wraps at 256, so take the shorter way round
    function automatic int unsigned hue_dist(input logic [7:0] a, input logic [7:0] b);
        int unsigned d;
        d = byte_dist(a, b);
        return (d < 256 - d) ? d : 256 - d;
    endfunction

    function automatic int unsigned rounded_avg(input int unsigned sum, input int unsigned n);
        return (sum + n / 2) / n;
    endfunction

    function automatic void restart_frame();
        cur_pos      = 0;
        sum_luma     = 0;
        sum_dluma    = 0;
        sum_dhue     = 0;
        sum_dsat     = 0;
        cur_compares = 1'b0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_SAMPLE_COUNT:
            begin
                // a new size invalidates the stored frame; any write drops the
                // frame in progress
                if (frame_size(val[COUNT_W-1:0]) != frame_size(reg_count))
                    stored_ok = 1'b0;
                reg_count = val[COUNT_W-1:0];
                restart_frame();
            end
            REG_LUMA_WEIGHT:       reg_wluma = val;
            REG_HUE_WEIGHT:        reg_whue = val;
            REG_SATURATION_WEIGHT: reg_wsat = val;
            default: ;
        endcase
    endfunction

    // Fold one accepted sample into the frame; queue a result at frame end.
    function automatic void accumulate_sample(input sample_req_t s);
        int unsigned        n;
        logic [3*PIX_W-1:0] old;
        longint unsigned    wsum;
        longint unsigned    wdelta;
        int unsigned        dl;
        int unsigned        dh;
        int unsigned        ds;
        int unsigned        score;
        result_t            res;
        n = frame_size(reg_count);
        if (cur_pos >= n)
            cur_pos = 0;
        if (cur_pos == 0)
        begin
            restart_frame();
            cur_compares = s.use_previous && stored_ok;
        end
        old = stored_frame[cur_pos];
        sum_luma += s.luma;
        if (cur_compares)
        begin
            sum_dluma += byte_dist(s.luma, old[23:16]);
            sum_dhue  += hue_dist(s.hue, old[15:8]);
            sum_dsat  += byte_dist(s.saturation, old[7:0]);
        end
        stored_frame[cur_pos] = {s.luma, s.hue, s.saturation};
        cur_pos++;
        if (cur_pos < n)
            return;

        dl    = 0;
        dh    = 0;
        ds    = 0;
        score = 0;
        if (cur_compares)
        begin
            dl     = rounded_avg(sum_dluma, n);
            dh     = rounded_avg(sum_dhue, n);
            ds     = rounded_avg(sum_dsat, n);
            wsum   = longint'(reg_wluma) + longint'(reg_whue) + longint'(reg_wsat);
            wdelta = longint'(dl) * reg_wluma + longint'(dh) * reg_whue
                   + longint'(ds) * reg_wsat;
            if (wsum != 0)
                score = (wdelta * 10000 + 127 * wsum) / (255 * wsum);
        end
        res.mean_luma        = rounded_avg(sum_luma, n);
        res.delta_luma       = dl;
        res.delta_hue        = dh;
        res.delta_saturation = ds;
        res.content_score    = score;
        res.had_previous     = cur_compares;
        expected_metrics.push_back(res);
        stored_ok = 1'b1;
        restart_frame();
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 150);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: take the next pending request whenever the slot frees up
    // ------------------------------------------------------------------------
    int unsigned send_gap = 0;
    sample_req_t next_req;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            send_gap     <= 0;
        end
        else
        begin
            // the ports still hold the request seen at this edge
            if (sample_valid && !sample_stall)
            begin
                accumulate_sample({luma, hue, saturation, use_previous});
                accepted_total++;
            end
            // hold a stalled request; otherwise idle or advance
            if (!sample_valid || !sample_stall)
            begin
                if (send_gap != 0)
                begin
                    sample_valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_req      = pending_requests.pop_front();
                    luma         <= next_req.luma;
                    hue          <= next_req.hue;
                    saturation   <= next_req.saturation;
                    use_previous <= next_req.use_previous;
                    sample_valid <= 1'b1;
                    send_gap     <= pick_gap();
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: random stall pattern, in-order compare
    // ------------------------------------------------------------------------
    int unsigned stall_hold = 0;
    result_t     want;

    function automatic void check_field(input string name, input logic [15:0] expv,
                                        input logic [15:0] actv);
        if (expv !== actv)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_hold   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_metrics.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d/%0d/%0d/%0d",
                             $time, mean_luma, delta_luma, delta_hue, delta_saturation,
                             content_score, had_previous);
                end
                else
                begin
                    want = expected_metrics.pop_front();
                    frames_checked++;
                    if (want.had_previous)
                        compared_frames++;
                    check_field("mean_luma", want.mean_luma, mean_luma);
                    check_field("delta_luma", want.delta_luma, delta_luma);
                    check_field("delta_hue", want.delta_hue, delta_hue);
                    check_field("delta_saturation", want.delta_saturation, delta_saturation);
                    check_field("content_score", want.content_score, content_score);
                    check_field("had_previous", want.had_previous, had_previous);
                end
            end
            // alternate open and stalled stretches of random length
            if (stall_hold != 0)
                stall_hold <= stall_hold - 1;
            else if (result_stall)
            begin
                result_stall <= 1'b0;
                stall_hold   <= calm ? 0 : $urandom_range(0, 6);
            end
            else
            begin
                result_stall <= (pick_gap() != 0);
                stall_hold   <= $urandom_range(0, 8);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    int unsigned gen_n = COUNT_RESET;   // effective frame size seen by the generator
    int unsigned gen_pos = 0;
    logic [7:0]  base_l;
    logic [7:0]  base_h;
    logic [7:0]  base_s;
    int unsigned random_items = 0;

    task automatic push_request(input logic [7:0] l, input logic [7:0] h,
                                input logic [7:0] s, input logic u);
        sample_req_t r;
        r.luma         = l;
        r.hue          = h;
        r.saturation   = s;
        r.use_previous = u;
        pending_requests.push_back(r);
        pushed_total++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        apply_register(idx, val);
        register_writes++;
        if (idx == REG_SAMPLE_COUNT)
        begin
            gen_n   = frame_size(val[COUNT_W-1:0]);
            gen_pos = 0;
        end
    endtask

    task automatic close_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Let every request go through and every result come back, then let the
    // block settle before touching its registers.
    task automatic wait_idle();
        while (accepted_total != pushed_total)
            @(posedge clk);
        while (expected_metrics.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Generate samples: 0 random, 1 jitter around a base (small deltas),
    // 2 byte extremes. use_previous matters only at a frame's first sample.
    task automatic send_samples(input int unsigned count, input int unsigned mode);
        int unsigned k;
        logic [7:0]  l;
        logic [7:0]  h;
        logic [7:0]  s;
        logic        u;
        for (k = 0; k < count; k++)
        begin
            case (mode)
                1:
                begin
                    l = base_l + $urandom_range(0, 6);
                    h = base_h + $urandom_range(0, 10) - 5;
                    s = base_s + $urandom_range(0, 6);
                end
                2:
                begin
                    l = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    h = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    s = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                default:
                begin
                    l = $urandom_range(0, 255);
                    h = $urandom_range(0, 255);
                    s = $urandom_range(0, 255);
                end
            endcase
            u = (gen_pos == 0) ? ($urandom_range(0, 4) != 0) : $urandom_range(0, 1);
            push_request(l, h, s, u);
            gen_pos = (gen_pos + 1 >= gen_n) ? 0 : gen_pos + 1;
        end
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 15);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_count();
        int unsigned r;
        logic [CFG_DATA_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 4)
            v = 0;                          // acts as one sample
        else if (r < 65)
            v = $urandom_range(1, 24);
        else if (r < 92)
            v = $urandom_range(25, 160);
        else
            v = $urandom_range(161, 700);
        // junk above the 13-bit field is dropped by the register
        if ($urandom_range(0, 7) == 0)
            v[CFG_DATA_W-1:COUNT_W] = $urandom_range(1, 7);
        return v;
    endfunction

    initial
    begin
        int unsigned frames;
        int unsigned f;
        int unsigned part;
        bit          first_setting;

        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        // Full-size frames at the reset settings: first one has nothing to
        // compare against, then a count above the store depth clamps to the
        // same size, keeps the stored frame and the second one can compare.
        base_l = $urandom_range(0, 255);
        base_h = $urandom_range(0, 255);
        base_s = $urandom_range(0, 255);
        send_samples(gen_n, 0);
        wait_idle();
        write_register(REG_SAMPLE_COUNT, 16'd8191);
        close_writes();
        send_samples(gen_n, 1);
        wait_idle();

        // One-sample frames (count zero acts as one) with luma-only weight:
        // top score, hue distance at its maximum, use_previous low.
        calm = 1'b1;
        write_register(REG_SAMPLE_COUNT, 16'd0);
        write_register(REG_LUMA_WEIGHT, 16'hFFFF);
        write_register(REG_HUE_WEIGHT, 16'h0000);
        write_register(REG_SATURATION_WEIGHT, 16'h0000);
        close_writes();
        push_request(8'd0, 8'd0, 8'd0, 1'b1);
        push_request(8'd255, 8'd128, 8'd255, 1'b1);
        push_request(8'd0, 8'd0, 8'd0, 1'b0);
        push_request(8'd0, 8'd0, 8'd0, 1'b1);
        wait_idle();

        // All weights zero: the score stays at zero; hue wraps round.
        calm = 1'b0;
        write_register(REG_LUMA_WEIGHT, 16'h0000);
        close_writes();
        push_request(8'd200, 8'd10, 8'd50, 1'b1);
        push_request(8'd55, 8'd250, 8'd0, 1'b1);
        wait_idle();

        // Three-sample frames: rounding of small sums, use_previous taken only
        // from the first sample, then an abandoned frame whose samples still
        // land in the store before a same-size rewrite of the count.
        write_register(REG_LUMA_WEIGHT, 16'd1);
        write_register(REG_HUE_WEIGHT, 16'hFFFF);
        write_register(REG_SATURATION_WEIGHT, 16'd1);
        write_register(REG_SAMPLE_COUNT, 16'd3);
        close_writes();
        push_request(8'd0, 8'd0, 8'd0, 1'b1);
        push_request(8'd0, 8'd0, 8'd1, 1'b0);
        push_request(8'd1, 8'd1, 8'd1, 1'b1);
        push_request(8'd255, 8'd255, 8'd255, 1'b0);
        push_request(8'd1, 8'd1, 8'd1, 1'b1);
        push_request(8'd0, 8'd0, 8'd0, 1'b1);
        push_request(8'd10, 8'd20, 8'd30, 1'b1);
        push_request(8'd40, 8'd50, 8'd60, 1'b0);
        wait_idle();
        write_register(REG_SAMPLE_COUNT, 16'd3);
        close_writes();
        push_request(8'd3, 8'd0, 8'd255, 1'b1);
        push_request(8'd128, 8'd128, 8'd128, 1'b0);
        push_request(8'd254, 8'd127, 8'd0, 1'b0);
        wait_idle();

        // Two-sample frames: half-way rounding goes up.
        write_register(REG_SAMPLE_COUNT, 16'd2);
        close_writes();
        push_request(8'd0, 8'd0, 8'd0, 1'b1);
        push_request(8'd1, 8'd0, 8'd0, 1'b1);
        push_request(8'd255, 8'd255, 8'd255, 1'b1);
        push_request(8'd254, 8'd0, 8'd255, 0);
        wait_idle();

        // Random phases: a new setting, a few frames of random content, and
        // now and then a frame left unfinished across the next setting.
        first_setting = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if (first_setting || $urandom_range(0, 99) < 65)
                write_register(REG_SAMPLE_COUNT, pick_count());
            if ($urandom_range(0, 9) < 6)
                write_register(REG_LUMA_WEIGHT, pick_weight());
            if ($urandom_range(0, 9) < 6)
                write_register(REG_HUE_WEIGHT, pick_weight());
            if ($urandom_range(0, 9) < 6)
                write_register(REG_SATURATION_WEIGHT, pick_weight());
            if ($urandom_range(0, 9) == 0)
                write_register(REG_LUMA_WEIGHT | REG_HUE_WEIGHT, 16'd0);
            close_writes();
            first_setting = 1'b0;

            base_l = $urandom_range(0, 255);
            base_h = $urandom_range(0, 255);
            base_s = $urandom_range(0, 255);
            frames = $urandom_range(1, 5);
            for (f = 0; f < frames; f++)
            begin
                random_items += gen_n - gen_pos;
                send_samples(gen_n - gen_pos, ($urandom_range(0, 9) < 5) ? 0 :
                             ($urandom_range(0, 3) != 0) ? 1 : 2);
            end
            if ($urandom_range(0, 9) == 0 && gen_n > 1)
            begin
                part = $urandom_range(1, gen_n - 1);
                random_items += part;
                send_samples(part, 0);
            end
            wait_idle();
        end

        // All requests are in and drained; look for stragglers.
        if (expected_metrics.size() != 0)
        begin
            error_count += expected_metrics.size();
            $display("%0t: %0d frame results never arrived: expected %0d, actual 0",
                     $time, expected_metrics.size(), expected_metrics.size());
        end

        $display("covered %0d samples, %0d frame results (%0d compared), %0d register writes",
                 accepted_total, frames_checked, compared_frames, register_writes);
        $display("mismatches: %0d", error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
